/* design/nps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants for the next prime search block
// Sequencer state encoding and the fixed constants of the search.
// ----------------------------------------------------------------------------
package nps_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV
   } state_type;

   // candidates below this have an empty divisor range
   localparam int SMALL_LIMIT       = 4;
   // first trial divisor once even candidates are ruled out
   localparam int FIRST_ODD_DIVISOR = 3;
   localparam int DIVISOR_STEP      = 2;

endpackage

/* design/nps_serial_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_serial_div: bit-serial restoring divider
// One quotient bit per cycle; WIDTH quotient bits per division after the start pulse.
// ----------------------------------------------------------------------------
module nps_serial_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // shift the next dividend bit into the partial remainder and try a subtract
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
         end else begin
            rem_in = shifted[WIDTH-1:0];
         end
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* design/next_prime_search_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_search_core: smallest trial-division prime at or above a value
// Steps candidates upward from the start value and tests each odd one from 5
// up with odd divisors on a bit-serial divider.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer a start value in. The block then
// scans candidates from that value upward and returns the first one with no
// divisor in 2..floor(c/2); 0, 1, 2 and 3 count as prime and a prime start
// value comes back unchanged. If the scan reaches all-ones the result is
// all-ones. The result is shown on rsp_prime_found for exactly one cycle with
// rsp_valid high; there is no back-pressure, so the receiver must take it in
// that cycle. busy drops in the same cycle, so a new start may be issued then.
// Flow: one item at a time. Each candidate is first screened in ST_TEST
// (range, small and even checks); every odd candidate from 5 up tries divisors
// 3, 5, 7 and upward until one divides it or the divisor passes floor(sqrt(c))
// (that last trial is still run), each trial running on the serial divider.
// ----------------------------------------------------------------------------
module next_prime_search_core
   import nps_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_start_value,
   output logic                   rsp_valid,
   output logic [VALUE_WIDTH-1:0] rsp_prime_found
);

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;   // candidate under test
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;     // current odd trial divisor
   logic [VALUE_WIDTH-1:0] rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;

   nps_serial_div #(
      .WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   (dsr_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer: screen a candidate, then run odd trial divisions on it
   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      dsr_in       = dsr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cand_in  = req_start_value;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (cand_ff == '1) begin
               // ran off the top: nothing qualifies
               rsp_in       = '1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cand_ff < VALUE_WIDTH'(SMALL_LIMIT)) begin
               rsp_in       = cand_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!cand_ff[0]) begin
               cand_in = cand_ff + 1'b1;
            end else begin
               dsr_in    = VALUE_WIDTH'(FIRST_ODD_DIVISOR);
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (dsr_ff > div_quo) begin
                  // divisor passed sqrt: no factor found
                  rsp_in       = cand_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (div_rem == '0) begin
                  cand_in  = cand_ff + 1'b1;
                  state_in = ST_TEST;
               end else begin
                  dsr_in    = dsr_ff + VALUE_WIDTH'(DIVISOR_STEP);
                  div_start = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      dsr_ff  <= dsr_in;
      rsp_ff  <= rsp_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_found = rsp_ff;

   // a transfer in always starts a search
   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted start did not raise busy");

   // exactly one result per item: never two strobes in a row
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // divider completions only arrive while the sequencer waits for them
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the division state");

   // trial divisors are always odd
   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> dsr_ff[0])
      else $error("even trial divisor in use");

endmodule
